>>> sv/pdcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdcp_pkg
// Types and codes shared by the distance constraint projection unit and its
// stream interfaces.
// ----------------------------------------------------------------------------
package pdcp_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KIND      = 1'd1;

	// constraint kinds
	localparam logic [1:0] KIND_EQUALITY       = 2'd0;
	localparam logic [1:0] KIND_INEQUALITY     = 2'd1;
	localparam logic [1:0] KIND_INV_INEQUALITY = 2'd2;

	// outcome codes
	localparam logic [1:0] OUTCOME_APPLIED     = 2'd0;
	localparam logic [1:0] OUTCOME_ZERO_WEIGHT = 2'd1;
	localparam logic [1:0] OUTCOME_SATISFIED   = 2'd2;
	localparam logic [1:0] OUTCOME_SATURATED   = 2'd3;

	// 1.0 in Q1.16
	localparam logic [16:0] Q16_ONE = 17'd65536;

	typedef struct packed {
		logic signed [31:0] pos_a_x;
		logic signed [31:0] pos_a_y;
		logic signed [31:0] pos_b_x;
		logic signed [31:0] pos_b_y;
		logic [23:0]        inv_mass_a;
		logic [23:0]        inv_mass_b;
		logic [30:0]        rest_distance;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_a_x;
		logic signed [31:0] new_a_y;
		logic signed [31:0] new_b_x;
		logic signed [31:0] new_b_y;
		logic [1:0]         outcome;
	} result_t;

endpackage
`default_nettype wire

>>> sv/pdcp_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdcp stream interfaces
// Valid/ready channels for constraint items and projection results.
// ----------------------------------------------------------------------------
interface pdcp_item_if;
	logic             valid;
	logic             ready;
	pdcp_pkg::item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pdcp_result_if;
	logic              valid;
	logic              ready;
	pdcp_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/pair_distance_constraint_projection_unit.sv
// accepts one item per cycle whenever the output register is free or being taken
// the pipeline depth comes from the 33-stage square root and the 31-stage dividers
// the whole pipeline advances together whenever the output register is free
// reset clears every valid bit, stiffness to 1.0 and kind to inequality
// ----------------------------------------------------------------------------
`default_nettype none
// ----------------------------------------------------------------------------
// pair_distance_constraint_projection_unit
// Projects one 2D distance constraint between two particles: root of the
// squared distance, normal and mass weights by division, then the moves.
// ----------------------------------------------------------------------------
module pair_distance_constraint_projection_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	pdcp_item_if.sink                               item,
	pdcp_result_if.source                           result,
	input  wire logic                               cfg_we,
	input  wire logic [pdcp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pdcp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	// stage map of the valid chain
	localparam int ROOT_STEPS = 33;
	localparam int DIV_STEPS  = 31;
	localparam int V_S4       = 3;
	localparam int V_SC       = V_S4 + ROOT_STEPS + 1;
	localparam int V_SG       = V_SC + DIV_STEPS + 1;
	localparam int V_SM       = V_SG + 1;
	localparam int V_SO       = V_SM + 1;
	localparam int NV         = V_SO + 1;

	// data that rides along the front end and the root
	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [32:0]        ux;
		logic [32:0]        uy;
		logic               neg_x;
		logic               neg_y;
		logic [40:0]        num_a;
		logic [40:0]        num_b;
		logic [24:0]        w;
		logic [30:0]        rest_d;
	} front_t;

	// data that rides along the dividers
	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic               neg_x;
		logic               neg_y;
		logic               cneg;
		logic [33:0]        uc;
		logic [1:0]         outcome;
	} back_t;

	// saturating move of one coordinate
	function automatic logic [32:0] sat_move(input logic signed [31:0] p,
			input logic [33:0] mag, input logic neg);
		logic [35:0] pe;
		logic [35:0] v;
		logic        ovf;
		pe  = {{4{p[31]}}, p};
		v   = neg ? pe - {2'b00, mag} : pe + {2'b00, mag};
		ovf = (v[35:31] != 5'b00000) && (v[35:31] != 5'b11111);
		if (ovf) begin
			return {1'b1, v[35] ? 32'h8000_0000 : 32'h7fff_ffff};
		end
		return {1'b0, v[31:0]};
	endfunction

	// ---------------------------------------------------------------- config
	logic [1:0]  kind_q;
	logic [16:0] kp_q;
	logic [16:0] kk;
	logic [16:0] m;
	logic [33:0] m_sq;

	// k' = 1 - (1-k)^2, formed from the write data so the next item sees it
	always_comb begin
		kk   = (cfg_wdata > pdcp_pkg::Q16_ONE) ? pdcp_pkg::Q16_ONE : cfg_wdata;
		m    = pdcp_pkg::Q16_ONE - kk;
		m_sq = {17'd0, m} * {17'd0, m};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q   <= pdcp_pkg::Q16_ONE;
			kind_q <= pdcp_pkg::KIND_INEQUALITY;
		end else if (cfg_we) begin
			case (cfg_index)
				pdcp_pkg::REG_STIFFNESS: kp_q   <= pdcp_pkg::Q16_ONE - m_sq[32:16];
				pdcp_pkg::REG_KIND:      kind_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- control
	logic          pipe_en;
	logic [NV-1:0] vld_q;

	// whole pipeline moves when the output register is empty or taken
	assign pipe_en    = !result.valid || result.ready;
	assign item.ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[NV-2:0], item.valid};
		end
	end

	// ---------------------------------------------------------------- s1: differences
	logic [32:0] dx;
	logic [32:0] dy;
	front_t      fr_s1;

	always_comb begin
		dx = {item.data.pos_a_x[31], item.data.pos_a_x}
			- {item.data.pos_b_x[31], item.data.pos_b_x};
		dy = {item.data.pos_a_y[31], item.data.pos_a_y}
			- {item.data.pos_b_y[31], item.data.pos_b_y};
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fr_s1.ax     <= item.data.pos_a_x;
			fr_s1.ay     <= item.data.pos_a_y;
			fr_s1.bx     <= item.data.pos_b_x;
			fr_s1.by     <= item.data.pos_b_y;
			fr_s1.neg_x  <= dx[32];
			fr_s1.neg_y  <= dy[32];
			fr_s1.ux     <= dx[32] ? -dx : dx;
			fr_s1.uy     <= dy[32] ? -dy : dy;
			// mass weight numerators k'*wa and k'*wb
			fr_s1.num_a  <= {24'd0, kp_q} * {17'd0, item.data.inv_mass_a};
			fr_s1.num_b  <= {24'd0, kp_q} * {17'd0, item.data.inv_mass_b};
			fr_s1.w      <= {1'b0, item.data.inv_mass_a} + {1'b0, item.data.inv_mass_b};
			fr_s1.rest_d <= item.data.rest_distance;
		end
	end

	// ---------------------------------------------------------------- s2: square partials
	front_t      fr_s2;
	logic [33:0] xhh_s2;
	logic [32:0] xhl_s2;
	logic [31:0] xll_s2;
	logic [33:0] yhh_s2;
	logic [32:0] yhl_s2;
	logic [31:0] yll_s2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fr_s2  <= fr_s1;
			xhh_s2 <= {17'd0, fr_s1.ux[32:16]} * {17'd0, fr_s1.ux[32:16]};
			xhl_s2 <= {16'd0, fr_s1.ux[32:16]} * {17'd0, fr_s1.ux[15:0]};
			xll_s2 <= {16'd0, fr_s1.ux[15:0]} * {16'd0, fr_s1.ux[15:0]};
			yhh_s2 <= {17'd0, fr_s1.uy[32:16]} * {17'd0, fr_s1.uy[32:16]};
			yhl_s2 <= {16'd0, fr_s1.uy[32:16]} * {17'd0, fr_s1.uy[15:0]};
			yll_s2 <= {16'd0, fr_s1.uy[15:0]} * {16'd0, fr_s1.uy[15:0]};
		end
	end

	// ---------------------------------------------------------------- s3: squares
	front_t      fr_s3;
	logic [65:0] sqx_s3;
	logic [65:0] sqy_s3;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fr_s3  <= fr_s2;
			// cross term counted twice, hence the shift by 17
			sqx_s3 <= {xhh_s2, 32'd0} + {16'd0, xhl_s2, 17'd0} + {34'd0, xll_s2};
			sqy_s3 <= {yhh_s2, 32'd0} + {16'd0, yhl_s2, 17'd0} + {34'd0, yll_s2};
		end
	end

	// ---------------------------------------------------------------- root pipeline
	// stage 0 is s4 (radicand), stages 1..33 produce one root bit each
	logic [65:0] rad_s  [0:ROOT_STEPS];
	logic [34:0] rrem_s [0:ROOT_STEPS];
	logic [32:0] root_s [0:ROOT_STEPS];
	front_t      fr_r_s [0:ROOT_STEPS];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			rad_s[0]  <= sqx_s3 + sqy_s3;
			rrem_s[0] <= '0;
			root_s[0] <= '0;
			fr_r_s[0] <= fr_s3;
		end
	end

	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		logic [36:0] t;
		logic [36:0] trial;
		logic [36:0] diff;
		logic        ge;

		always_comb begin
			t     = {rrem_s[k], rad_s[k][65:64]};
			trial = {2'b00, root_s[k], 2'b01};
			diff  = t - trial;
			ge    = t >= trial;
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rad_s[k+1]  <= {rad_s[k][63:0], 2'b00};
				rrem_s[k+1] <= ge ? diff[34:0] : t[34:0];
				root_s[k+1] <= {root_s[k][31:0], ge};
				fr_r_s[k+1] <= fr_r_s[k];
			end
		end
	end

	// ---------------------------------------------------------------- sc: error and skip test
	front_t      fr_e;
	logic [32:0] len;
	logic [34:0] c;
	logic        cneg;
	logic [1:0]  pre_outcome;
	back_t       bk_sc;
	logic [40:0] num_a_sc;
	logic [40:0] num_b_sc;
	logic [24:0] w_sc;
	logic [62:0] nnx_sc;
	logic [62:0] nny_sc;
	logic [32:0] len_sc;

	always_comb begin
		fr_e = fr_r_s[ROOT_STEPS];
		len  = root_s[ROOT_STEPS];
		c    = {2'b00, len} - {4'b0000, fr_e.rest_d};
		cneg = c[34];
		if (fr_e.w == '0 || len == '0) begin
			pre_outcome = pdcp_pkg::OUTCOME_ZERO_WEIGHT;
		end else if ((kind_q == pdcp_pkg::KIND_INEQUALITY && !cneg)
				|| (kind_q == pdcp_pkg::KIND_INV_INEQUALITY && (cneg || c == '0))) begin
			pre_outcome = pdcp_pkg::OUTCOME_SATISFIED;
		end else begin
			pre_outcome = pdcp_pkg::OUTCOME_APPLIED;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			bk_sc.ax      <= fr_e.ax;
			bk_sc.ay      <= fr_e.ay;
			bk_sc.bx      <= fr_e.bx;
			bk_sc.by      <= fr_e.by;
			bk_sc.neg_x   <= fr_e.neg_x;
			bk_sc.neg_y   <= fr_e.neg_y;
			bk_sc.cneg    <= cneg;
			bk_sc.uc      <= cneg ? 34'(-c) : c[33:0];
			bk_sc.outcome <= pre_outcome;
			num_a_sc      <= fr_e.num_a;
			num_b_sc      <= fr_e.num_b;
			w_sc          <= fr_e.w;
			nnx_sc        <= {fr_e.ux, 30'd0};
			nny_sc        <= {fr_e.uy, 30'd0};
			len_sc        <= len;
		end
	end

	// ---------------------------------------------------------------- dividers
	// fa, fb = k'*w / (wa+wb) in Q1.16; nx, ny = |d| / len in Q1.30
	logic [DIV_STEPS-1:0] fa_q;
	logic [DIV_STEPS-1:0] fb_q;
	logic [DIV_STEPS-1:0] nx_q;
	logic [DIV_STEPS-1:0] ny_q;

	pdcp_div #(.NUM_W(41), .DEN_W(25), .Q_W(DIV_STEPS)) u_div_fa (
		.clk(clk), .en(pipe_en), .num(num_a_sc), .den(w_sc), .quo(fa_q)
	);
	pdcp_div #(.NUM_W(41), .DEN_W(25), .Q_W(DIV_STEPS)) u_div_fb (
		.clk(clk), .en(pipe_en), .num(num_b_sc), .den(w_sc), .quo(fb_q)
	);
	pdcp_div #(.NUM_W(63), .DEN_W(33), .Q_W(DIV_STEPS)) u_div_nx (
		.clk(clk), .en(pipe_en), .num(nnx_sc), .den(len_sc), .quo(nx_q)
	);
	pdcp_div #(.NUM_W(63), .DEN_W(33), .Q_W(DIV_STEPS)) u_div_ny (
		.clk(clk), .en(pipe_en), .num(nny_sc), .den(len_sc), .quo(ny_q)
	);

	// side data delayed to line up with the quotients
	back_t bk_d_s [0:DIV_STEPS];

	assign bk_d_s[0] = bk_sc;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_bk
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				bk_d_s[j+1] <= bk_d_s[j];
			end
		end
	end

	// ---------------------------------------------------------------- sg: scaled error
	back_t       bk_sg;
	logic [50:0] pga;
	logic [50:0] pgb;
	logic [33:0] ga_sg;
	logic [33:0] gb_sg;
	logic [30:0] nx_sg;
	logic [30:0] ny_sg;

	always_comb begin
		pga = {17'd0, bk_d_s[DIV_STEPS].uc} * {34'd0, fa_q[16:0]};
		pgb = {17'd0, bk_d_s[DIV_STEPS].uc} * {34'd0, fb_q[16:0]};
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			bk_sg <= bk_d_s[DIV_STEPS];
			ga_sg <= pga[49:16];
			gb_sg <= pgb[49:16];
			nx_sg <= nx_q;
			ny_sg <= ny_q;
		end
	end

	// ---------------------------------------------------------------- sm: step sizes
	back_t       bk_sm;
	logic [64:0] pax;
	logic [64:0] pay;
	logic [64:0] pbx;
	logic [64:0] pby;
	logic [33:0] max_sm;
	logic [33:0] may_sm;
	logic [33:0] mbx_sm;
	logic [33:0] mby_sm;

	always_comb begin
		pax = {31'd0, ga_sg} * {34'd0, nx_sg};
		pay = {31'd0, ga_sg} * {34'd0, ny_sg};
		pbx = {31'd0, gb_sg} * {34'd0, nx_sg};
		pby = {31'd0, gb_sg} * {34'd0, ny_sg};
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			bk_sm  <= bk_sg;
			max_sm <= pax[63:30];
			may_sm <= pay[63:30];
			mbx_sm <= pbx[63:30];
			mby_sm <= pby[63:30];
		end
	end

	// ---------------------------------------------------------------- so: moves and output
	logic [32:0]       nax;
	logic [32:0]       nay;
	logic [32:0]       nbx;
	logic [32:0]       nby;
	logic              skip;
	pdcp_pkg::result_t res_so;

	// a moves against the signed step, b along it
	always_comb begin
		nax  = sat_move(bk_sm.ax, max_sm, bk_sm.cneg == bk_sm.neg_x);
		nay  = sat_move(bk_sm.ay, may_sm, bk_sm.cneg == bk_sm.neg_y);
		nbx  = sat_move(bk_sm.bx, mbx_sm, bk_sm.cneg != bk_sm.neg_x);
		nby  = sat_move(bk_sm.by, mby_sm, bk_sm.cneg != bk_sm.neg_y);
		skip = bk_sm.outcome != pdcp_pkg::OUTCOME_APPLIED;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			if (skip) begin
				res_so.new_a_x <= bk_sm.ax;
				res_so.new_a_y <= bk_sm.ay;
				res_so.new_b_x <= bk_sm.bx;
				res_so.new_b_y <= bk_sm.by;
				res_so.outcome <= bk_sm.outcome;
			end else begin
				res_so.new_a_x <= nax[31:0];
				res_so.new_a_y <= nay[31:0];
				res_so.new_b_x <= nbx[31:0];
				res_so.new_b_y <= nby[31:0];
				res_so.outcome <= (nax[32] || nay[32] || nbx[32] || nby[32])
					? pdcp_pkg::OUTCOME_SATURATED : pdcp_pkg::OUTCOME_APPLIED;
			end
		end
	end

	assign result.valid = vld_q[V_SO];
	assign result.data  = res_so;

	// ---------------------------------------------------------------- checks
	// full stiffness write, with no write right after it, must give k' of one
	a_kp_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == pdcp_pkg::REG_STIFFNESS
			&& cfg_wdata >= pdcp_pkg::Q16_ONE) ##1 !cfg_we
		|=> kp_q == pdcp_pkg::Q16_ONE)
		else $error("k' not one after full stiffness write");

	// a stall freezes the valid bit of every in-flight item
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> vld_q == $past(vld_q))
		else $error("valid chain moved during stall");

	// the stage counts add up to the result register
	a_chain_top: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[V_SM] && pipe_en) |=> result.valid)
		else $error("item lost between step stage and output");

endmodule
`default_nettype wire

>>> sv/pdcp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdcp_div
// Pipelined restoring divider, one quotient bit per stage, Q_W stages.
// Needs num < den * 2**Q_W.
// ----------------------------------------------------------------------------
module pdcp_div #(
	parameter int NUM_W = 63,
	parameter int DEN_W = 33,
	parameter int Q_W   = 31
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic      [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]   low_s [0:Q_W];
	logic [Q_W-1:0]   quo_s [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];

	// upper numerator bits are already below den
	assign rem_s[0] = DEN_W'(num >> Q_W);
	assign low_s[0] = num[Q_W-1:0];
	assign quo_s[0] = '0;
	assign den_s[0] = den;

	for (genvar j = 0; j < Q_W; j++) begin : g_step
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;
		logic [DEN_W-1:0] nrem;

		always_comb begin
			trial = {rem_s[j], low_s[j][Q_W-1]};
			diff  = trial - {1'b0, den_s[j]};
			ge    = trial >= {1'b0, den_s[j]};
			nrem  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= nrem;
				low_s[j+1] <= {low_s[j][Q_W-2:0], 1'b0};
				quo_s[j+1] <= {quo_s[j][Q_W-2:0], ge};
				den_s[j+1] <= den_s[j];
			end
		end
	end

	assign quo = quo_s[Q_W];

endmodule
`default_nettype wire

>>> tb/sv/pair_distance_constraint_projection_unit_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_distance_constraint_projection_unit_checker
// Watches the item, result and configuration ports. It predicts each
// projection and compares it, field by field, with the results in order.
// ----------------------------------------------------------------------------
module pair_distance_constraint_projection_unit_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	pdcp_item_if                                 item,
	pdcp_result_if                               result,
	input  wire logic                            cfg_we,
	input  wire logic [pdcp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pdcp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                                   fail_count,
	output int                                   outstanding
);
	import pdcp_pkg::*;

	logic [16:0] stiffness;
	logic [1:0]  kind;
	result_t     projections[$];

	// floor of the square root of a sum of two squares, up to 2^65
	function automatic logic [32:0] root_of(input logic [65:0] v);
		logic [32:0] r;
		logic [32:0] cand;
		r = '0;
		for (int i = 32; i >= 0; i--) begin
			cand = r | (33'd1 << i);
			if ({35'd0, cand} * {35'd0, cand} <= {2'd0, v})
				r = cand;
		end
		return r;
	endfunction

	// moved coordinate with its saturation flag on top
	function automatic logic [32:0] moved(input longint p, input longint mag, input bit neg);
		longint v;
		v = neg ? p - mag : p + mag;
		if (v > 64'sd2147483647)
			return {1'b1, 32'h7FFF_FFFF};
		if (v < -64'sd2147483648)
			return {1'b1, 32'h8000_0000};
		return {1'b0, v[31:0]};
	endfunction

	function automatic result_t project(input item_t it, input logic [16:0] stf,
			input logic [1:0] knd);
		result_t r;
		longint dx, dy, c;
		longint unsigned ux, uy, len, w, kk, m, kp, fa, fb, uc, ga, gb, nx, ny;
		logic [65:0] sq;
		logic [32:0] ax_n, ay_n, bx_n, by_n;
		bit cneg;
		dx = longint'(it.pos_a_x) - longint'(it.pos_b_x);
		dy = longint'(it.pos_a_y) - longint'(it.pos_b_y);
		ux = dx < 0 ? -dx : dx;
		uy = dy < 0 ? -dy : dy;
		sq = {2'd0, ux} * {2'd0, ux} + {2'd0, uy} * {2'd0, uy};
		len = {31'd0, root_of(sq)};
		w = it.inv_mass_a + it.inv_mass_b;
		c = longint'(len) - longint'(it.rest_distance);
		r.new_a_x = it.pos_a_x;
		r.new_a_y = it.pos_a_y;
		r.new_b_x = it.pos_b_x;
		r.new_b_y = it.pos_b_y;
		if (w == 0 || len == 0) begin
			r.outcome = OUTCOME_ZERO_WEIGHT;
			return r;
		end
		if ((knd == KIND_INEQUALITY && c >= 0) || (knd == KIND_INV_INEQUALITY && c <= 0)) begin
			r.outcome = OUTCOME_SATISFIED;
			return r;
		end
		kk = stf > Q16_ONE ? Q16_ONE : stf;
		m = Q16_ONE - kk;
		kp = Q16_ONE - ((m * m) >> 16);
		fa = (kp * it.inv_mass_a) / w;
		fb = (kp * it.inv_mass_b) / w;
		cneg = c < 0;
		uc = cneg ? -c : c;
		ga = (uc * fa) >> 16;
		gb = (uc * fb) >> 16;
		nx = (ux << 30) / len;
		ny = (uy << 30) / len;
		// a moves against g*n, b moves along it
		ax_n = moved(it.pos_a_x, (ga * nx) >> 30, cneg == (dx < 0));
		ay_n = moved(it.pos_a_y, (ga * ny) >> 30, cneg == (dy < 0));
		bx_n = moved(it.pos_b_x, (gb * nx) >> 30, cneg != (dx < 0));
		by_n = moved(it.pos_b_y, (gb * ny) >> 30, cneg != (dy < 0));
		r.new_a_x = ax_n[31:0];
		r.new_a_y = ay_n[31:0];
		r.new_b_x = bx_n[31:0];
		r.new_b_y = by_n[31:0];
		r.outcome = (ax_n[32] | ay_n[32] | bx_n[32] | by_n[32]) ? OUTCOME_SATURATED
			: OUTCOME_APPLIED;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness <= Q16_ONE;
			kind <= KIND_INEQUALITY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STIFFNESS: stiffness <= cfg_wdata;
				REG_KIND:      kind <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && item.valid && item.ready)
			projections.insert(projections.size(), project(item.data, stiffness, kind));
		if (arst_n && result.valid && result.ready) begin
			if (projections.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				exp_r = projections.pop_front();
				if (result.data.new_a_x !== exp_r.new_a_x) begin
					$error("new_a_x expected %0d got %0d", exp_r.new_a_x, result.data.new_a_x);
					fail_count++;
				end
				if (result.data.new_a_y !== exp_r.new_a_y) begin
					$error("new_a_y expected %0d got %0d", exp_r.new_a_y, result.data.new_a_y);
					fail_count++;
				end
				if (result.data.new_b_x !== exp_r.new_b_x) begin
					$error("new_b_x expected %0d got %0d", exp_r.new_b_x, result.data.new_b_x);
					fail_count++;
				end
				if (result.data.new_b_y !== exp_r.new_b_y) begin
					$error("new_b_y expected %0d got %0d", exp_r.new_b_y, result.data.new_b_y);
					fail_count++;
				end
				if (result.data.outcome !== exp_r.outcome) begin
					$error("outcome expected %0d got %0d", exp_r.outcome, result.data.outcome);
					fail_count++;
				end
			end
		end
		outstanding = projections.size();
	end

endmodule
`default_nettype wire

>>> tb/sv/pair_distance_constraint_projection_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_distance_constraint_projection_unit_tb
// Drives constraint items and register writes into the projection unit under
// random idling and back pressure; the checker beside it does the comparing.
// ----------------------------------------------------------------------------
module pair_distance_constraint_projection_unit_tb;
	import pdcp_pkg::*;

	localparam int PIPE_DRAIN  = 100;     // a margin beyond the pipeline depth
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int fail_count, outstanding;
	int cycles = 0;

	// idling percentages of the current phase
	int send_idle = 0;
	int recv_stall = 0;
	// long receiver hold-off, requested by the stimulus and counted below
	bit hold_req = 0;
	int hold_left = 0;

	pdcp_item_if item_ch ();
	pdcp_result_if result_ch ();

	initial begin
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
	end

	always #6 clk = ~clk;

	pair_distance_constraint_projection_unit u_top (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(result_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	pair_distance_constraint_projection_unit_checker u_checker (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(result_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	// receiver: random stalls, plus the long hold-off that fills the pipeline
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// one item transfer; valid stays high when the next item follows at once
	task automatic send_constraint(input item_t it);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (PIPE_DRAIN) @(negedge clk);
	endtask

	// registers are only written with the pipeline empty
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t mk(input logic [31:0] ax, ay, bx, by,
			input logic [23:0] wa, wb, input logic [30:0] rd);
		item_t it;
		it.pos_a_x = ax;
		it.pos_a_y = ay;
		it.pos_b_x = bx;
		it.pos_b_y = by;
		it.inv_mass_a = wa;
		it.inv_mass_b = wb;
		it.rest_distance = rd;
		return it;
	endfunction

	function automatic logic [23:0] rand_mass();
		case ($urandom_range(7))
			0:       return '0;
			1:       return 24'hFF_FFFF;
			2:       return 24'h01_0000;
			default: return 24'($urandom);
		endcase
	endfunction

	// mostly nearby pairs with a rest distance around their separation, so
	// every kind lands on both sides of its test; some fully random pairs
	function automatic item_t rand_constraint();
		item_t it;
		int unsigned span, ox, oy;
		it = mk($urandom, $urandom, $urandom, $urandom, rand_mass(), rand_mass(),
			31'($urandom));
		if ($urandom_range(9) < 7) begin
			span = 1 << $urandom_range(4, 28);
			ox = $urandom_range(span);
			oy = $urandom_range(span);
			it.pos_b_x = it.pos_a_x + ($urandom_range(1) ? ox : -ox);
			it.pos_b_y = it.pos_a_y + ($urandom_range(1) ? oy : -oy);
			if ($urandom_range(15) == 0)
				it.pos_b_y = it.pos_a_y;
			if ($urandom_range(31) == 0) begin
				it.pos_b_x = it.pos_a_x;
				it.pos_b_y = it.pos_a_y;
			end
			it.rest_distance = 31'($urandom_range(0, 2 * (ox + oy) + 1));
		end
		return it;
	endfunction

	initial begin
		int phase_idle[4];
		int phase_stall[4];
		logic [16:0] stf_set[6];
		phase_idle  = '{0, 63, 0, 14};
		phase_stall = '{0, 0, 63, 14};
		stf_set = '{Q16_ONE, 17'd0, 17'd32768, 17'h1FFFF, 17'd1, 17'd65535};

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at the reset settings: stiffness 1.0, keep apart
		send_constraint(mk(32'h0001_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0002_0000));
		send_constraint(mk(32'h0003_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0002_0000));
		// zero weight, both particles fixed
		send_constraint(mk(32'h0001_0000, 0, 0, 0, 0, 0, 31'h0002_0000));
		// one fixed particle
		send_constraint(mk(0, 32'h0000_8000, 0, 0, 0, 24'hFF_FFFF, 31'h7FFF_FFFF));
		// coincident particles
		send_constraint(mk(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321,
			24'h01_0000, 24'h01_0000, 31'h0001_0000));
		// widest separation, both corners
		send_constraint(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			24'hFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF));
		send_constraint(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			24'h00_0001, 24'hFF_FFFF, 31'h0));
		// pushed apart past the edges of the range
		send_constraint(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000, 32'h8000_FFFF,
			24'h01_0000, 24'h01_0000, 31'h7FFF_FFFF));
		send_constraint(mk(32'h8000_0000, 0, 32'h8000_0100, 0, 24'hFF_FFFF, 1, 31'h4000_0000));
		// exactly at rest distance
		send_constraint(mk(32'h0003_0000, 32'h0004_0000, 0, 0, 24'h01_0000, 24'h02_0000,
			31'h0005_0000));
		// axis aligned in y, negative offsets
		send_constraint(mk(0, 32'hFFFF_0000, 0, 32'h0001_0000, 24'h00_8000, 24'h00_8000,
			31'h0010_0000));
		send_constraint(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 24'hFF_FFFF, 24'hFF_FFFF,
			31'h7FFF_FFFF));
		// equality and inverse inequality on the same few pairs
		write_reg(REG_KIND, CFG_DATA_W'(KIND_EQUALITY));
		send_constraint(mk(32'h0003_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0001_0000));
		send_constraint(mk(32'h0001_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0003_0000));
		write_reg(REG_KIND, CFG_DATA_W'(KIND_INV_INEQUALITY));
		send_constraint(mk(32'h0003_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0001_0000));
		send_constraint(mk(32'h0001_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0003_0000));
		send_constraint(mk(32'h0005_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0005_0000));
		// kind 3 behaves as equality
		write_reg(REG_KIND, 17'd3);
		send_constraint(mk(32'h0003_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0001_0000));
		// stiffness above 1.0 and zero stiffness
		write_reg(REG_STIFFNESS, 17'h1FFFF);
		send_constraint(mk(32'h0003_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0001_0000));
		write_reg(REG_STIFFNESS, 17'd0);
		send_constraint(mk(32'h0003_0000, 0, 0, 0, 24'h01_0000, 24'h01_0000, 31'h0001_0000));

		// random part: four idling phases, each stepping through settings
		for (int p = 0; p < 4; p++) begin
			send_idle = phase_idle[p];
			recv_stall = phase_stall[p];
			for (int s = 0; s < 6; s++) begin
				write_reg(REG_STIFFNESS, (s == 5) ? 17'($urandom) : stf_set[(s + p) % 6]);
				write_reg(REG_KIND, CFG_DATA_W'((s + p) % 4));
				// long hold-off while items keep coming in the no-idle phase
				if (p == 0 && s == 1)
					hold_req = 1;
				for (int n = 0; n < 80; n++)
					send_constraint(rand_constraint());
				// a sender pause until every result is back
				if (s == 3)
					drain();
			end
		end

		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

>>> filelist.f
sv/pdcp_pkg.sv
sv/pdcp_ifs.sv
sv/pdcp_div.sv
sv/pair_distance_constraint_projection_unit.sv
tb/sv/pair_distance_constraint_projection_unit_checker.sv
tb/sv/pair_distance_constraint_projection_unit_tb.sv
